### sv/gwc_pkg.sv
// Shared types and constants of the grid ray wall caster.
`timescale 1ns / 1ps
package gwc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 6;
  localparam int POS_W      = COORD_W + FRAC_BITS;
  localparam int DIR_W      = 18;
  localparam int DIST_W     = 32;
  localparam int CODE_W     = 8;
  localparam int SCREEN_W   = 12;
  localparam int TEXW_W     = 13;
  localparam int HEIGHT_W   = 16;
  localparam int COL_W      = 12;
  localparam int IN_DATA_W  = 232;
  localparam int OUT_DATA_W = 104;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int DIV_NUM_W  = 40;
  localparam int DIV_DEN_W  = 32;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_CAST  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_SCREEN_H  = 3'd0,
    CFG_WALL      = 3'd1,
    CFG_SPRITE    = 3'd2,
    CFG_TEX_WEST  = 3'd3,
    CFG_TEX_EAST  = 3'd4,
    CFG_TEX_SOUTH = 3'd5,
    CFG_TEX_NORTH = 3'd6,
    CFG_TEX_SPRT  = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FACE_WEST   = 3'd0,
    FACE_EAST   = 3'd1,
    FACE_SOUTH  = 3'd2,
    FACE_NORTH  = 3'd3,
    FACE_SPRITE = 3'd4
  } face_e;

  // input word fields, lowest last
  typedef struct packed {
    logic [31:0]         delta_dist_y;
    logic [31:0]         delta_dist_x;
    logic [31:0]         side_dist_y;
    logic [31:0]         side_dist_x;
    logic [DIR_W-1:0]    ray_dir_y;
    logic [DIR_W-1:0]    ray_dir_x;
    logic [POS_W-1:0]    pos_y;
    logic [POS_W-1:0]    pos_x;
    logic [CODE_W-1:0]   cell_value;
    logic [COORD_W-1:0]  write_y;
    logic [COORD_W-1:0]  write_x;
  } in_fields_t;

  typedef struct packed {
    logic       is_cast;
    in_fields_t f;
  } cmd_t;

  typedef struct packed {
    logic [SCREEN_W-1:0] screen_height;
    logic [CODE_W-1:0]   wall_code;
    logic [CODE_W-1:0]   sprite_code;
    logic [TEXW_W-1:0]   tex_west;
    logic [TEXW_W-1:0]   tex_east;
    logic [TEXW_W-1:0]   tex_south;
    logic [TEXW_W-1:0]   tex_north;
    logic [TEXW_W-1:0]   tex_sprite;
  } cfg_t;

  // result word fields, lowest last
  typedef struct packed {
    logic                walk_fault;
    logic                bad_cell;
    logic [COL_W-1:0]    tex_column;
    logic [SCREEN_W-1:0] line_end;
    logic [SCREEN_W-1:0] line_start;
    logic [HEIGHT_W-1:0] line_height;
    logic [2:0]          face;
    logic [COORD_W-1:0]  hit_y;
    logic [COORD_W-1:0]  hit_x;
    logic                wall_side;
    logic [DIST_W-1:0]   wall_distance;
  } result_t;

endpackage

### sv/gwc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module gwc_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [DEN_W:0]   rem_sh, diff;

  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!diff[DEN_W]) begin
        rem_q <= diff[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### sv/gwc_front.sv
// Front end: takes input words, classifies the command, queues two deep.
`timescale 1ns / 1ps
module gwc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [gwc_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tuser,
  output logic                          q_valid_o,
  output gwc_pkg::cmd_t                 q_cmd_o,
  input  logic                          q_pop_i
);

  gwc_pkg::cmd_t fifo_q [2];
  gwc_pkg::cmd_t in_cmd;
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          push;

  assign in_cmd.is_cast = (gwc_pkg::cmd_e'(s_axis_tuser) == gwc_pkg::CMD_CAST);
  assign in_cmd.f       = gwc_pkg::in_fields_t'(s_axis_tdata[$bits(gwc_pkg::in_fields_t)-1:0]);

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != 2'd0);
  assign q_cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= in_cmd;
  end

endmodule

### sv/gwc_back.sv
// Back end: map store, DDA walk, distance, line span and texture column.
`timescale 1ns / 1ps
module gwc_back #(
  parameter int MAX_STEPS = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gwc_pkg::cfg_t    cfg_i,
  input  logic             q_valid_i,
  input  gwc_pkg::cmd_t    q_cmd_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output gwc_pkg::result_t out_data_o
);

  localparam int SW = $clog2(MAX_STEPS + 1);
  localparam int FB = gwc_pkg::FRAC_BITS;
  localparam int CW = gwc_pkg::COORD_W;
  localparam int AW = 2 * CW;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_STEP  = 10'b0000000010,
    S_CHK   = 10'b0000000100,
    S_DIST  = 10'b0000001000,
    S_DWAIT = 10'b0000010000,
    S_HGT   = 10'b0000100000,
    S_HWAIT = 10'b0001000000,
    S_MUL1  = 10'b0010000000,
    S_MUL2  = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  gwc_pkg::in_fields_t cmd_q, cmd_d;
  logic [CW-1:0]   mx_q, mx_d, my_q, my_d;
  logic [31:0]     sdx_q, sdx_d, sdy_q, sdy_d;
  logic            side_q, side_d, fault_q, fault_d;
  logic [SW-1:0]   steps_q, steps_d;
  logic [7:0]      cell_q, cell_d, rdata_q;
  logic [31:0]     dist_q, dist_d;
  logic [15:0]     h_q, h_d;
  logic signed [50:0] prod_q, prod_d;
  logic [44:0]     fw_q, fw_d;
  logic [2:0]      face_q, face_d;
  logic            bad_q, bad_d;
  logic [12:0]     width_q, width_d;
  logic            out_valid_q;
  gwc_pkg::result_t out_data_q, res;

  logic [7:0] map_q [2**AW];
  logic           mem_we;
  logic [AW-1:0]  rd_addr;

  logic           div_start, div_done;
  logic [39:0]    div_num, div_quo;
  logic [31:0]    div_den;

  gwc_div #(.NUM_W(gwc_pkg::DIV_NUM_W), .DEN_W(gwc_pkg::DIV_DEN_W)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  // walk step
  logic        take_x, neg_x, neg_y, leave;
  logic [CW-1:0] nx, ny;
  logic [32:0] sum_x, sum_y;
  assign neg_x  = cmd_q.ray_dir_x[17];
  assign neg_y  = cmd_q.ray_dir_y[17];
  assign take_x = sdx_q < sdy_q;
  assign sum_x  = {1'b0, sdx_q} + {1'b0, cmd_q.delta_dist_x};
  assign sum_y  = {1'b0, sdy_q} + {1'b0, cmd_q.delta_dist_y};
  assign nx     = neg_x ? mx_q - 1'b1 : mx_q + 1'b1;
  assign ny     = neg_y ? my_q - 1'b1 : my_q + 1'b1;
  assign leave  = take_x ? (neg_x ? (mx_q == '0) : (mx_q == '1))
                         : (neg_y ? (my_q == '0) : (my_q == '1));

  // distance setup
  logic [CW-1:0]          m_sel;
  logic [21:0]            p_sel, p_oth;
  logic [17:0]            dir_sel, dir_oth, dir_abs;
  logic signed [24:0]     num;
  logic [24:0]            num_abs;
  assign m_sel   = side_q ? my_q : mx_q;
  assign p_sel   = side_q ? cmd_q.pos_y : cmd_q.pos_x;
  assign p_oth   = side_q ? cmd_q.pos_x : cmd_q.pos_y;
  assign dir_sel = side_q ? cmd_q.ray_dir_y : cmd_q.ray_dir_x;
  assign dir_oth = side_q ? cmd_q.ray_dir_x : cmd_q.ray_dir_y;
  assign dir_abs = dir_sel[17] ? (~dir_sel + 1'b1) : dir_sel;
  assign num     = $signed({3'b000, m_sel, {FB{1'b0}}}) - $signed({3'b000, p_sel})
                 + (dir_sel[17] ? 25'sd65536 : 25'sd0);
  assign num_abs = num[24] ? -num : num;

  // final fields
  logic [12:0]        col;
  logic               mirror;
  logic signed [14:0] colm;
  logic signed [16:0] ls;
  logic [16:0]        le;
  logic [11:0]        col_o, ls_o, le_o;
  logic [31:0]        frac;

  assign frac   = {p_oth[FB-1:0], {FB{1'b0}}} + prod_q[31:0];
  assign col    = fw_q[44:32];
  assign mirror = (!side_q && !neg_x && (cmd_q.ray_dir_x != '0)) || (side_q && neg_y);
  assign colm   = $signed({2'b00, width_q}) - $signed({2'b00, col}) - 15'sd1;
  assign ls     = $signed({6'd0, cfg_i.screen_height[11:1]}) - $signed({2'b00, h_q[15:1]});
  assign le     = {2'b00, h_q[15:1]} + {6'd0, cfg_i.screen_height[11:1]};

  always_comb begin
    if (mirror) begin
      if (colm < 0) col_o = '0;
      else if (colm > 15'sd4095) col_o = 12'hFFF;
      else col_o = colm[11:0];
    end else begin
      col_o = (col > 13'd4095) ? 12'hFFF : col[11:0];
    end
    ls_o = ls[16] ? '0 : ls[11:0];
    if (le >= {5'd0, cfg_i.screen_height}) begin
      le_o = (cfg_i.screen_height == '0) ? '0 : cfg_i.screen_height - 1'b1;
    end else begin
      le_o = le[11:0];
    end
    res = '0;
    if (fault_q) begin
      res.walk_fault = 1'b1;
    end else begin
      res.wall_distance = dist_q;
      res.wall_side     = side_q;
      res.hit_x         = mx_q;
      res.hit_y         = my_q;
      res.face          = face_q;
      res.line_height   = h_q;
      res.line_start    = ls_o;
      res.line_end      = le_o;
      res.tex_column    = col_o;
      res.bad_cell      = bad_q;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q; mx_d = mx_q; my_d = my_q; sdx_d = sdx_q; sdy_d = sdy_q;
    side_d = side_q; fault_d = fault_q; steps_d = steps_q; cell_d = cell_q;
    dist_d = dist_q; h_d = h_q; prod_d = prod_q; fw_d = fw_q;
    face_d = face_q; bad_d = bad_q; width_d = width_q;
    q_pop_o = 1'b0; mem_we = 1'b0; div_start = 1'b0;
    div_num = '0; div_den = '0;
    rd_addr = {mx_q, my_q};
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.is_cast) begin
            cmd_d   = q_cmd_i.f;
            mx_d    = q_cmd_i.f.pos_x[21:FB];
            my_d    = q_cmd_i.f.pos_y[21:FB];
            sdx_d   = q_cmd_i.f.side_dist_x;
            sdy_d   = q_cmd_i.f.side_dist_y;
            side_d  = 1'b0;
            fault_d = 1'b0;
            steps_d = '0;
            state_d = S_STEP;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      S_STEP: begin
        steps_d = steps_q + 1'b1;
        if (take_x) begin
          sdx_d   = sum_x[32] ? 32'hFFFF_FFFF : sum_x[31:0];
          mx_d    = nx;
          side_d  = 1'b0;
          rd_addr = {nx, my_q};
        end else begin
          sdy_d   = sum_y[32] ? 32'hFFFF_FFFF : sum_y[31:0];
          my_d    = ny;
          side_d  = 1'b1;
          rd_addr = {mx_q, ny};
        end
        if (leave) begin
          fault_d = 1'b1;
          state_d = S_FIN;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        cell_d = rdata_q;
        if (rdata_q == cfg_i.wall_code) state_d = S_DIST;
        else if (steps_q == SW'(MAX_STEPS)) begin
          fault_d = 1'b1;
          state_d = S_FIN;
        end else state_d = S_STEP;
      end
      S_DIST: begin
        if (dir_sel == '0) begin
          dist_d  = 32'hFFFF_FFFF;
          state_d = S_HGT;
        end else if ((num[24] != dir_sel[17]) && (num != '0)) begin
          dist_d  = '0;
          state_d = S_HGT;
        end else begin
          div_start = 1'b1;
          div_num   = {num_abs[23:0], {FB{1'b0}}};
          div_den   = {14'd0, dir_abs};
          state_d   = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (div_done) begin
          dist_d  = (div_quo[39:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
          state_d = S_HGT;
        end
      end
      S_HGT: begin
        if (dist_q == '0) begin
          h_d     = 16'hFFFF;
          state_d = S_MUL1;
        end else begin
          div_start = 1'b1;
          div_num   = {12'd0, cfg_i.screen_height, {FB{1'b0}}};
          div_den   = dist_q;
          state_d   = S_HWAIT;
        end
      end
      S_HWAIT: begin
        if (div_done) begin
          h_d     = (div_quo[39:16] != '0) ? 16'hFFFF : div_quo[15:0];
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        prod_d = $signed({1'b0, dist_q}) * $signed(dir_oth);
        bad_d  = 1'b0;
        if (cell_q == cfg_i.wall_code) begin
          if (!side_q) face_d = (cmd_q.pos_x[21:FB] < mx_q) ? gwc_pkg::FACE_WEST
                                                          : gwc_pkg::FACE_EAST;
          else face_d = (cmd_q.pos_y[21:FB] < my_q) ? gwc_pkg::FACE_SOUTH
                                                    : gwc_pkg::FACE_NORTH;
        end else if (cell_q == cfg_i.sprite_code) begin
          face_d = gwc_pkg::FACE_SPRITE;
        end else begin
          face_d = gwc_pkg::FACE_WEST;
          bad_d  = 1'b1;
        end
        state_d = S_MUL2;
      end
      S_MUL2: begin
        unique case (gwc_pkg::face_e'(face_q))
          gwc_pkg::FACE_WEST:   width_d = cfg_i.tex_west;
          gwc_pkg::FACE_EAST:   width_d = cfg_i.tex_east;
          gwc_pkg::FACE_SOUTH:  width_d = cfg_i.tex_south;
          gwc_pkg::FACE_NORTH:  width_d = cfg_i.tex_north;
          gwc_pkg::FACE_SPRITE: width_d = cfg_i.tex_sprite;
          default:              width_d = cfg_i.tex_west;
        endcase
        fw_d    = frac * width_d;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIN && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; mx_q <= mx_d; my_q <= my_d; sdx_q <= sdx_d; sdy_q <= sdy_d;
    side_q <= side_d; fault_q <= fault_d; steps_q <= steps_d; cell_q <= cell_d;
    dist_q <= dist_d; h_q <= h_d; prod_q <= prod_d; fw_q <= fw_d;
    face_q <= face_d; bad_q <= bad_d; width_q <= width_d;
    if (state_q == S_FIN && (!out_valid_q || out_ready_i)) out_data_q <= res;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) map_q[{q_cmd_i.f.write_x, q_cmd_i.f.write_y}] <= q_cmd_i.f.cell_value;
    rdata_q <= map_q[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### sv/grid_ray_wall_caster.sv
// Top level of the grid ray wall caster: config registers, front and back.
// A map write waits in the front queue and lands in the map when the back end pops
// it while idle; a cast walks the DDA for at most MAX_STEPS steps, then runs the
// distance and height divisions; zero direction or distance skips one.
// Throughput: one cast at a time, paced by the bit-serial divider runs and the
// registered map read of each walk step. Writes retire 1 a cycle while no cast runs.
// Reset: asynchronous, active low; returns control and config registers to their
// defaults, map contents stay undefined until written.
`timescale 1ns / 1ps
module grid_ray_wall_caster #(
  parameter int MAX_STEPS = 128
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // write_x, write_y, cell_value, pos_x, pos_y, ray_dir_x, ray_dir_y,
  // side_dist_x, side_dist_y, delta_dist_x, delta_dist_y, zero pad
  input  logic [gwc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // command
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // wall_distance, wall_side, hit_x, hit_y, face, line_height, line_start,
  // line_end, tex_column, bad_cell, walk_fault, zero pad
  output logic [gwc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gwc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gwc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  gwc_pkg::cfg_t    cfg_q;
  gwc_pkg::cmd_t    q_cmd;
  gwc_pkg::result_t res;
  logic             q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_height <= 12'd480;
      cfg_q.wall_code     <= 8'd1;
      cfg_q.sprite_code   <= 8'd2;
      cfg_q.tex_west      <= 13'd64;
      cfg_q.tex_east      <= 13'd64;
      cfg_q.tex_south     <= 13'd64;
      cfg_q.tex_north     <= 13'd64;
      cfg_q.tex_sprite    <= 13'd64;
    end else if (cfg_valid_i) begin
      unique case (gwc_pkg::cfg_idx_e'(cfg_index_i))
        gwc_pkg::CFG_SCREEN_H:  cfg_q.screen_height <= cfg_data_i[11:0];
        gwc_pkg::CFG_WALL:      cfg_q.wall_code     <= cfg_data_i[7:0];
        gwc_pkg::CFG_SPRITE:    cfg_q.sprite_code   <= cfg_data_i[7:0];
        gwc_pkg::CFG_TEX_WEST:  cfg_q.tex_west      <= cfg_data_i;
        gwc_pkg::CFG_TEX_EAST:  cfg_q.tex_east      <= cfg_data_i;
        gwc_pkg::CFG_TEX_SOUTH: cfg_q.tex_south     <= cfg_data_i;
        gwc_pkg::CFG_TEX_NORTH: cfg_q.tex_north     <= cfg_data_i;
        gwc_pkg::CFG_TEX_SPRT:  cfg_q.tex_sprite    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gwc_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .q_valid_o(q_valid), .q_cmd_o(q_cmd), .q_pop_i(q_pop)
  );

  gwc_back #(.MAX_STEPS(MAX_STEPS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .q_valid_i(q_valid), .q_cmd_i(q_cmd),
    .q_pop_o(q_pop), .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(res)
  );

  assign m_axis_tdata = {{(gwc_pkg::OUT_DATA_W - $bits(gwc_pkg::result_t)){1'b0}}, res};

endmodule

### sv/gwc_checker.sv
// Port-level checks on the result stream of the grid ray wall caster.
`timescale 1ns / 1ps
module gwc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [gwc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_fault_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[101] |-> m_axis_tdata[100:0] == '0)
    else $error("fault word carries data");

  a_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[101] |-> m_axis_tdata[75:64] <= m_axis_tdata[87:76])
    else $error("line start beyond line end");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[101] && m_axis_tdata[31:0] == '0
    |-> m_axis_tdata[63:48] == 16'hFFFF)
    else $error("zero distance without saturated height");

endmodule

bind grid_ray_wall_caster gwc_checker u_gwc_checker (.*);

### dv/tb_grid_ray_wall_caster.sv
// Self-checking testbench of the grid ray wall caster: map fill, directed and random casts.
`timescale 1ns / 1ps
module tb_grid_ray_wall_caster;
  import gwc_pkg::*;

  localparam int GRID      = 64;
  localparam int BOX       = 16;
  localparam int STEP_CAP  = 128;
  localparam int IDLE_MAX  = 20000;
  localparam int IN_W      = $bits(in_fields_t);

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  grid_ray_wall_caster u_top (.*);

  always #1 clk_i = ~clk_i;

  // shadow of the block's state
  logic [7:0]           grid_codes [GRID*GRID];
  logic [SCREEN_W-1:0]  scr_h;
  logic [CODE_W-1:0]    wall_cd;
  logic [CODE_W-1:0]    sprite_cd;
  logic [TEXW_W-1:0]    tex_w [5];

  result_t expected_hits[$];
  int      mismatches;
  int      idle_cycles;
  int      burst_left;

  typedef struct {
    cmd_e       cmd;
    in_fields_t f;
    bit         typed;
    result_t    res;
  } row_t;
  row_t rows[$];

  function automatic longint unsigned sat32(longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  function automatic result_t cast_ray(in_fields_t f);
    longint px, py, dx, dy, stx, sty, mx, my, num, den, h, rs, ls, le, full, col;
    longint unsigned sdx, sdy, ddx, ddy, wdist, an, ad, fr, wd;
    int side;
    bit hit;
    int fc;
    logic [7:0] hit_code;
    result_t r;
    r = '0;
    px = f.pos_x; py = f.pos_y;
    dx = $signed(f.ray_dir_x); dy = $signed(f.ray_dir_y);
    sdx = f.side_dist_x; sdy = f.side_dist_y;
    ddx = f.delta_dist_x; ddy = f.delta_dist_y;
    stx = dx < 0 ? -1 : 1;
    sty = dy < 0 ? -1 : 1;
    mx = px >>> FRAC_BITS; my = py >>> FRAC_BITS;
    side = 0; hit = 1'b0;
    if (mx < GRID && my < GRID) begin
      for (int s = 0; s < STEP_CAP; s++) begin
        if (sdx < sdy) begin
          sdx = sat32(sdx + ddx); mx += stx; side = 0;
        end else begin
          sdy = sat32(sdy + ddy); my += sty; side = 1;
        end
        if (mx < 0 || mx >= GRID || my < 0 || my >= GRID) break;
        if (grid_codes[mx*GRID+my] == wall_cd) begin
          hit = 1'b1;
          break;
        end
      end
    end
    if (!hit) begin
      r.walk_fault = 1'b1;
      return r;
    end
    if (side == 0) begin
      num = (mx <<< FRAC_BITS) - px + (stx < 0 ? (64'sd1 <<< FRAC_BITS) : 0);
      den = dx;
    end else begin
      num = (my <<< FRAC_BITS) - py + (sty < 0 ? (64'sd1 <<< FRAC_BITS) : 0);
      den = dy;
    end
    if (den == 0) wdist = 64'hFFFF_FFFF;
    else if (((num < 0) != (den < 0)) && num != 0) wdist = 0;
    else begin
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      wdist = sat32((an << FRAC_BITS) / ad);
    end
    if (wdist == 0) h = 65535;
    else begin
      an = ((64'(scr_h)) << FRAC_BITS) / wdist;
      h = an > 65535 ? 65535 : an;
    end
    rs = scr_h;
    ls = rs / 2 - h / 2;
    le = h / 2 + rs / 2;
    if (ls < 0) ls = 0;
    if (le >= rs) le = rs - 1;
    if (le < 0) le = 0;
    hit_code = grid_codes[mx*GRID+my];
    fc = FACE_WEST;
    if (hit_code == wall_cd) begin
      if (side == 0) fc = px < (mx <<< FRAC_BITS) ? FACE_WEST : FACE_EAST;
      else fc = py < (my <<< FRAC_BITS) ? FACE_SOUTH : FACE_NORTH;
    end else if (hit_code == sprite_cd) fc = FACE_SPRITE;
    else r.bad_cell = 1'b1;
    wd = tex_w[fc];
    full = (side == 0) ? (py <<< FRAC_BITS) + longint'(wdist) * dy
                       : (px <<< FRAC_BITS) + longint'(wdist) * dx;
    fr = full & 64'hFFFF_FFFF;
    col = longint'((fr * wd) >> 32);
    if ((side == 0 && dx > 0) || (side == 1 && dy < 0)) col = longint'(wd) - col - 1;
    if (col < 0) col = 0;
    if (col > 4095) col = 4095;
    r.wall_distance = 32'(wdist);
    r.wall_side     = 1'(side);
    r.hit_x         = 6'(mx);
    r.hit_y         = 6'(my);
    r.face          = 3'(fc);
    r.line_height   = 16'(h);
    r.line_start    = 12'(ls);
    r.line_end      = 12'(le);
    r.tex_column    = 12'(col);
    return r;
  endfunction

  task automatic send_word(cmd_e cmd, in_fields_t f, bit typed, result_t res);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W-$bits(in_fields_t)){1'b0}}, f};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == CMD_WRITE) grid_codes[f.write_x*GRID+f.write_y] = f.cell_value;
    else expected_hits.push_back(typed ? res : cast_ray(f));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SCREEN_H: scr_h     = val[SCREEN_W-1:0];
      CFG_WALL:     wall_cd   = val[CODE_W-1:0];
      CFG_SPRITE:   sprite_cd = val[CODE_W-1:0];
      default:      tex_w[idx - CFG_TEX_WEST] = val;
    endcase
  endtask

  function automatic logic [7:0] pick_code();
    logic [7:0] codes [5] = '{8'd1, 8'd2, 8'd3, 8'd7, 8'd255};
    return ($urandom_range(0, 9) < 7) ? 8'd0 : codes[$urandom_range(0, 4)];
  endfunction

  function automatic in_fields_t write_fields(int x, int y, logic [7:0] v);
    in_fields_t f;
    f = '0;
    f.write_x = 6'(x); f.write_y = 6'(y); f.cell_value = v;
    return f;
  endfunction

  // walled box in the grid corner keeps every walk on written cells
  task automatic wall_box(logic [7:0] code);
    for (int x = 0; x < BOX; x++)
      for (int y = 0; y < BOX; y++)
        if (x == 0 || y == 0 || x == BOX-1 || y == BOX-1)
          send_word(CMD_WRITE, write_fields(x, y, code), 0, '0);
  endtask

  // well-formed ray: side and delta distances consistent with position and direction
  function automatic in_fields_t good_ray();
    in_fields_t f;
    longint dx, dy, fx, fy;
    longint unsigned ddx, ddy;
    f = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom});
    f.pos_x = {6'($urandom_range(1, BOX-2)), 16'($urandom)};
    f.pos_y = {6'($urandom_range(1, BOX-2)), 16'($urandom)};
    case ($urandom_range(0, 9))
      0: f.ray_dir_x = '0;
      1: f.ray_dir_y = '0;
      2: f.ray_dir_x = 18'h20000;
      default: ;
    endcase
    dx = $signed(f.ray_dir_x); dy = $signed(f.ray_dir_y);
    fx = f.pos_x[15:0]; fy = f.pos_y[15:0];
    ddx = dx == 0 ? 64'hFFFF_FFFF : sat32(64'h1_0000_0000 / (dx < 0 ? -dx : dx));
    ddy = dy == 0 ? 64'hFFFF_FFFF : sat32(64'h1_0000_0000 / (dy < 0 ? -dy : dy));
    f.delta_dist_x = 32'(ddx);
    f.delta_dist_y = 32'(ddy);
    f.side_dist_x  = 32'(sat32(((dx < 0 ? fx : 65536 - fx) * ddx) >> 16));
    f.side_dist_y  = 32'(sat32(((dy < 0 ? fy : 65536 - fy) * ddy) >> 16));
    return f;
  endfunction

  function automatic void add_row(cmd_e cmd, in_fields_t f, bit typed = 0,
                                  result_t res = '0);
    row_t r;
    r.cmd = cmd; r.f = f; r.typed = typed; r.res = res;
    rows.push_back(r);
  endfunction

  function automatic in_fields_t ray(longint px, longint py, longint dx, longint dy,
                                     longint unsigned sx, longint unsigned sy,
                                     longint unsigned ddx, longint unsigned ddy);
    in_fields_t f;
    f = '0;
    f.pos_x = 22'(px); f.pos_y = 22'(py); f.ray_dir_x = 18'(dx); f.ray_dir_y = 18'(dy);
    f.side_dist_x = 32'(sx); f.side_dist_y = 32'(sy);
    f.delta_dist_x = 32'(ddx); f.delta_dist_y = 32'(ddy);
    return f;
  endfunction

  // receiver stalls
  int rx_mode, rx_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_left = 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 300);
      end
      rx_left--;
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic check_field(string nm, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", nm, e, a);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t got, exp_r;
    if (rst_ni) begin
      idle_cycles++;
      if ((s_axis_tvalid && s_axis_tready) || (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
      if (m_axis_tvalid && m_axis_tready) begin
        idle_cycles = 0;
        got = m_axis_tdata[$bits(result_t)-1:0];
        if (expected_hits.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          exp_r = expected_hits.pop_front();
          check_field("wall_distance", exp_r.wall_distance, got.wall_distance);
          check_field("wall_side", exp_r.wall_side, got.wall_side);
          check_field("hit_x", exp_r.hit_x, got.hit_x);
          check_field("hit_y", exp_r.hit_y, got.hit_y);
          check_field("face", exp_r.face, got.face);
          check_field("line_height", exp_r.line_height, got.line_height);
          check_field("line_start", exp_r.line_start, got.line_start);
          check_field("line_end", exp_r.line_end, got.line_end);
          check_field("tex_column", exp_r.tex_column, got.tex_column);
          check_field("bad_cell", exp_r.bad_cell, got.bad_cell);
          check_field("walk_fault", exp_r.walk_fault, got.walk_fault);
        end
      end
      if (idle_cycles >= IDLE_MAX) begin
        $display("grid_ray_wall_caster test failed");
        $finish;
      end
    end
  end

  initial begin
    result_t zd, wf;
    in_fields_t f;
    int n;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_SCREEN_H;
    cfg_data_i    <= '0;
    mismatches = 0; idle_cycles = 0; burst_left = 0;
    scr_h = 480; wall_cd = 1; sprite_cd = 2;
    foreach (tex_w[i]) tex_w[i] = 64;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner box written first, walled border
    for (int x = 0; x < BOX; x++)
      for (int y = 0; y < BOX; y++)
        send_word(CMD_WRITE, write_fields(x, y,
          (x == 0 || y == 0 || x == BOX-1 || y == BOX-1) ? 8'd1 : pick_code()), 0, '0);

    // zero distance: start on a grid line, step straight into the border
    zd = '0;
    zd.hit_x = 6'd0; zd.hit_y = 6'd1; zd.face = FACE_EAST;
    zd.line_height = 16'hFFFF; zd.line_start = 12'd0; zd.line_end = 12'd479;
    wf = '0;
    wf.walk_fault = 1'b1;
    add_row(CMD_CAST, ray(32'h1_0000, 32'h1_0000, -65536, 0, 0, 32'hFFFF_FFFF,
                          65536, 32'hFFFF_FFFF), 1, zd);
    // leaves the grid from the far corner
    add_row(CMD_CAST, ray(22'h3F_FFFF, 22'h3F_FFFF, 65536, 65536, 0, 32'hFFFF_FFFF,
                          65536, 65536), 1, wf);
    add_row(CMD_CAST, ray(0, 0, -1, -1, 5, 0, 65536, 65536), 1, wf);
    add_row(CMD_WRITE, write_fields(5, 9, 8'd1));
    add_row(CMD_WRITE, write_fields(20, 20, 8'd255));
    add_row(CMD_WRITE, write_fields(10, 10, 8'd0));
    add_row(CMD_WRITE, write_fields(63, 63, 8'd1));
    add_row(CMD_CAST, ray(32'h5_8000, 32'h5_8000, 0, 65536, 32'hFFFF_FFFF, 32'h8000,
                          32'hFFFF_FFFF, 65536));
    add_row(CMD_CAST, ray(32'h5_0000, 32'h5_0000, 0, 0, 0, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_row(CMD_CAST, ray(32'h8_0000, 32'h8_0000, -131072, 131071, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    add_row(CMD_CAST, ray(32'h7_FFFF, 32'h9_0001, 131071, -131072, 32'h8000, 32'h7FFF,
                          32'h8000, 32'h8000));
    add_row(CMD_CAST, ray(32'hE_FFFF, 32'h01_0000, 131071, -1, 0, 1, 0, 0));
    for (int i = 0; i < 6; i++) add_row(CMD_CAST, good_ray());
    foreach (rows[i]) send_word(rows[i].cmd, rows[i].f, rows[i].typed, rows[i].res);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_SCREEN_H,
                ph == 0 ? 13'd1 : ph == 1 ? 13'd4095 : 13'($urandom_range(1, 4095)));
      case (ph)
        0: write_reg(CFG_WALL, 13'd1);
        1: write_reg(CFG_WALL, 13'd0);
        2: write_reg(CFG_WALL, 13'd255);
        3: write_reg(CFG_WALL, 13'd200);
        default: write_reg(CFG_WALL, 13'(pick_code()));
      endcase
      write_reg(CFG_SPRITE, ph == 2 ? 13'd255 : 13'($urandom_range(0, 255)));
      for (int t = 0; t < 5; t++)
        write_reg(cfg_idx_e'(CFG_TEX_WEST + t),
                  ph == 0 ? 13'd1 : ph == 1 ? 13'd4096 : 13'($urandom_range(1, 4096)));
      cfg_valid_i <= 1'b0;
      wall_box(wall_cd);
      n = 0;
      while (n < 100) begin
        case ($urandom_range(0, 9))
          0: send_word(CMD_WRITE, write_fields($urandom_range(1, BOX-2),
                                               $urandom_range(1, BOX-2),
                                               ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                           : pick_code()),
                       0, '0);
          1: begin
            f = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom});
            f.pos_x[21:16] = 6'($urandom_range(1, BOX-2));
            f.pos_y[21:16] = 6'($urandom_range(1, BOX-2));
            send_word(CMD_CAST, f, 0, '0);
          end
          default: send_word(CMD_CAST, good_ray(), 0, '0);
        endcase
        n++;
      end
      drain();
    end

    drain();
    repeat (400) @(posedge clk_i);
    if (mismatches == 0 && expected_hits.size() == 0)
      $display("grid_ray_wall_caster test passed");
    else
      $display("grid_ray_wall_caster test failed");
    $finish;
  end

endmodule

### filelist.f
sv/gwc_pkg.sv
sv/gwc_div.sv
sv/gwc_front.sv
sv/gwc_back.sv
sv/grid_ray_wall_caster.sv
sv/gwc_checker.sv
dv/tb_grid_ray_wall_caster.sv
